// ----- rtl/cscg_pkg.sv -----
// ----------------------------------------------------------------------------
// cscg_pkg
// Shared types and constants for the companded sample gain block.
// ----------------------------------------------------------------------------
package cscg_pkg;

  localparam int unsigned SAMPLE_W           = 8;
  localparam int unsigned MAG_W              = 15;
  localparam int unsigned GAIN_W             = 16;
  localparam int unsigned LIN_W              = 16;
  localparam int unsigned ADDR_W             = 4;
  localparam int unsigned DATA_W             = 32;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 12;

  localparam logic [MAG_W-1:0]  LIN_MAX    = 15'h7FFF;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  localparam logic LAW_MU = 1'b0;
  localparam logic LAW_A  = 1'b1;

  localparam logic [1:0] REG_LAW = 2'd0;
  localparam logic [1:0] REG_RX  = 2'd1;
  localparam logic [1:0] REG_TX  = 2'd2;

  typedef struct packed {
    logic valid;
    logic law;
  } cscg_ctrl_t;

endpackage

// ----- rtl/cscg_expand.sv -----
// ----------------------------------------------------------------------------
// cscg_expand
// First stage: expands a companded byte to sign and linear magnitude.
// ----------------------------------------------------------------------------
module cscg_expand (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cscg_pkg::cscg_ctrl_t             ctrl_i,
  input  logic [cscg_pkg::SAMPLE_W-1:0]    sample_i,
  output cscg_pkg::cscg_ctrl_t             ctrl_o,
  output logic                             neg_o,
  output logic [cscg_pkg::MAG_W-1:0]       mag_o
);
  import cscg_pkg::*;

  localparam logic [MAG_W-1:0] MU_BIAS = 15'd132;

  cscg_ctrl_t              ctrl_q;
  logic                    neg_d, neg_q;
  logic [MAG_W-1:0]        mag_d, mag_q;
  logic [SAMPLE_W-1:0]     u, a;
  logic [MAG_W-1:0]        mu_t, a_t;
  logic [2:0]              a_seg;

  always_comb begin
    u     = ~sample_i;
    a     = sample_i ^ 8'h55;
    a_seg = a[6:4];
    mu_t  = ({7'd0, 1'b0, u[3:0], 3'd0} + MU_BIAS) << u[6:4];
    if (a_seg == 3'd0) begin
      a_t = {7'd0, a[3:0], 4'd0} + 15'd8;
    end else begin
      a_t = ({7'd0, a[3:0], 4'd0} + 15'd264) << (a_seg - 3'd1);
    end
    if (ctrl_i.law == LAW_A) begin
      mag_d = a_t;
      neg_d = ~a[7];
    end else begin
      mag_d = mu_t - MU_BIAS;
      neg_d = u[7];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
  end

  assign ctrl_o = ctrl_q;
  assign neg_o  = neg_q;
  assign mag_o  = mag_q;

endmodule

// ----- rtl/cscg_scale.sv -----
// ----------------------------------------------------------------------------
// cscg_scale
// Second and third stages: gain multiply, then truncate, clamp and sign.
// ----------------------------------------------------------------------------
module cscg_scale #(
  parameter int unsigned GAIN_FRAC_BITS = cscg_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cscg_pkg::cscg_ctrl_t             ctrl_i,
  input  logic                             neg_i,
  input  logic [cscg_pkg::MAG_W-1:0]       mag_i,
  input  logic [cscg_pkg::GAIN_W-1:0]      gain_i,
  output cscg_pkg::cscg_ctrl_t             ctrl_o,
  output logic signed [cscg_pkg::LIN_W-1:0] lin_o
);
  import cscg_pkg::*;

  localparam int unsigned PROD_W = MAG_W + GAIN_W;

  cscg_ctrl_t              ctrl2_q, ctrl3_q;
  logic [PROD_W-1:0]       prod_d, prod_q;
  logic                    neg2_q;
  logic [PROD_W-1:0]       shifted;
  logic [MAG_W-1:0]        clamped;
  logic signed [LIN_W-1:0] lin_d, lin_q;

  // stage 2: multiply
  assign prod_d = PROD_W'(mag_i) * PROD_W'(gain_i);

  // stage 3: truncate toward zero, clamp, apply sign
  always_comb begin
    shifted = prod_q >> GAIN_FRAC_BITS;
    if (shifted > PROD_W'(LIN_MAX)) begin
      clamped = LIN_MAX;
    end else begin
      clamped = shifted[MAG_W-1:0];
    end
    if (neg2_q) begin
      lin_d = -$signed({1'b0, clamped});
    end else begin
      lin_d = $signed({1'b0, clamped});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl2_q <= '0;
      ctrl3_q <= '0;
    end else begin
      ctrl2_q <= ctrl_i;
      ctrl3_q <= ctrl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg2_q <= neg_i;
    lin_q  <= lin_d;
  end

  assign ctrl_o = ctrl3_q;
  assign lin_o  = lin_q;

endmodule

// ----- rtl/cscg_compress.sv -----
// ----------------------------------------------------------------------------
// cscg_compress
// Fourth stage: re-encodes a clamped linear value in mu-law or A-law.
// ----------------------------------------------------------------------------
module cscg_compress (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cscg_pkg::cscg_ctrl_t              ctrl_i,
  input  logic signed [cscg_pkg::LIN_W-1:0] lin_i,
  output cscg_pkg::cscg_ctrl_t              ctrl_o,
  output logic [cscg_pkg::SAMPLE_W-1:0]     code_o
);
  import cscg_pkg::*;

  function automatic logic [7:0] mu_code(input logic signed [15:0] v);
    logic [13:0] p;
    logic [13:0] m;
    logic [7:0]  mask;
    logic [3:0]  seg;
    logic [13:0] mant;
    p = v[15:2];
    if (p[13]) begin
      m    = -p;
      mask = 8'h7F;
    end else begin
      m    = p;
      mask = 8'hFF;
    end
    if (m > 14'd8159) begin
      m = 14'd8159;
    end
    m   = m + 14'd33;
    seg = 4'd0;
    for (int i = 1; i < 8; i++) begin
      if (m[i+5]) begin
        seg = 4'(i);
      end
    end
    if (m[13]) begin
      return 8'h7F ^ mask;
    end
    mant = m >> (seg + 4'd1);
    return {1'b0, seg[2:0], mant[3:0]} ^ mask;
  endfunction

  function automatic logic [7:0] a_code(input logic signed [15:0] v);
    logic [12:0] p;
    logic [11:0] m;
    logic [7:0]  mask;
    logic [2:0]  seg;
    logic [11:0] mant;
    p = v[15:3];
    if (!p[12]) begin
      m    = p[11:0];
      mask = 8'hD5;
    end else begin
      m    = ~p[11:0];
      mask = 8'h55;
    end
    seg = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (m[i+4]) begin
        seg = 3'(i);
      end
    end
    if (seg < 3'd2) begin
      mant = m >> 1;
    end else begin
      mant = m >> seg;
    end
    return {1'b0, seg, mant[3:0]} ^ mask;
  endfunction

  cscg_ctrl_t          ctrl_q;
  logic [SAMPLE_W-1:0] code_d, code_q;

  assign code_d = (ctrl_i.law == LAW_A) ? a_code(lin_i) : mu_code(lin_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign ctrl_o = ctrl_q;
  assign code_o = code_q;

endmodule

// ----- rtl/companded_sample_gain.sv -----
// ----------------------------------------------------------------------------
// companded_sample_gain
// Digital gain on G.711 samples: expand, multiply, clamp, re-encode.
// ----------------------------------------------------------------------------
// Takes one sample byte per cycle: busy stays low, so start may be held high
// every cycle. Each word comes out on sample_out_o with valid_o after it has
// passed through the expand, multiply, clamp and encode stages, one result per
// word, in order. The output cannot be stalled; results must be captured in
// the cycle valid_o is high. Law and gains are read over the APB port and
// should only change while no words are in flight.
module companded_sample_gain #(
  parameter int unsigned GAIN_FRAC_BITS = cscg_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [cscg_pkg::SAMPLE_W-1:0]    sample_in_i,
  input  logic                             path_i,
  output logic                             valid_o,
  output logic [cscg_pkg::SAMPLE_W-1:0]    sample_out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cscg_pkg::ADDR_W-1:0]      paddr,
  input  logic [cscg_pkg::DATA_W-1:0]      pwdata,
  output logic [cscg_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);
  import cscg_pkg::*;

  logic              law_q;
  logic [GAIN_W-1:0] rx_gain_q, tx_gain_q;
  logic [GAIN_W-1:0] gain_d, gain_q;
  logic              accept, wr_en;
  logic [1:0]        reg_idx;
  cscg_ctrl_t        in_ctrl, exp_ctrl, scl_ctrl, out_ctrl;
  logic              exp_neg;
  logic [MAG_W-1:0]  exp_mag;
  logic signed [LIN_W-1:0] scl_lin;

  // config registers
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      law_q     <= LAW_MU;
      rx_gain_q <= GAIN_RESET;
      tx_gain_q <= GAIN_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LAW: law_q     <= pwdata[0];
        REG_RX:  rx_gain_q <= pwdata[GAIN_W-1:0];
        REG_TX:  tx_gain_q <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LAW: prdata = {{(DATA_W-1){1'b0}}, law_q};
      REG_RX:  prdata = {{(DATA_W-GAIN_W){1'b0}}, rx_gain_q};
      REG_TX:  prdata = {{(DATA_W-GAIN_W){1'b0}}, tx_gain_q};
      default: prdata = '0;
    endcase
  end

  // input word
  assign busy          = 1'b0;
  assign accept        = start & ~busy;
  assign in_ctrl.valid = accept;
  assign in_ctrl.law   = law_q;
  assign gain_d        = path_i ? tx_gain_q : rx_gain_q;

  always_ff @(posedge clk_i) begin
    gain_q <= gain_d;
  end

  cscg_expand u_expand (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (in_ctrl),
    .sample_i (sample_in_i),
    .ctrl_o   (exp_ctrl),
    .neg_o    (exp_neg),
    .mag_o    (exp_mag)
  );

  cscg_scale #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (exp_ctrl),
    .neg_i  (exp_neg),
    .mag_i  (exp_mag),
    .gain_i (gain_q),
    .ctrl_o (scl_ctrl),
    .lin_o  (scl_lin)
  );

  cscg_compress u_compress (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scl_ctrl),
    .lin_i  (scl_lin),
    .ctrl_o (out_ctrl),
    .code_o (sample_out_o)
  );

  assign valid_o = out_ctrl.valid;

  // every accepted word gives exactly one result once it leaves the pipeline
  a_latency_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 valid_o)
    else $error("accepted word did not produce a result");

  a_latency_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##4 !valid_o)
    else $error("result without an accepted word");

  a_rx_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && reg_idx == REG_RX) |=> rx_gain_q == $past(pwdata[GAIN_W-1:0]))
    else $error("receive gain write lost");

endmodule
